// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the DES round function checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define DESRF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Concurrent assertion that is checked during reset as well.
`define DESRF_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ----- design/desrf_pkg.sv -----
// ----------------------------------------------------------------------------
// desrf_pkg
// Types, tables and helper functions for the DES round function.
// ----------------------------------------------------------------------------
package desrf_pkg;

    localparam int unsigned HALF_W = 32;
    localparam int unsigned KEY_W  = 48;
    localparam int unsigned NIB_W  = 4;
    localparam int unsigned GRP_W  = 6;
    localparam int unsigned N_BOX  = 8;

    // Input register contents handed to the round logic.
    typedef struct packed {
        logic                valid;
        logic [HALF_W-1:0]   right_half;
        logic [KEY_W-1:0]    round_key;
    } t_stage;

    // Source bit (1 = MSB) of the right half for each expanded bit, MSB first.
    localparam logic [5:0] EXP_SRC [0:KEY_W-1] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    // Source bit (1 = MSB) of the S-box word for each output bit of P.
    localparam logic [5:0] PERM_SRC [0:HALF_W-1] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // The eight standard S-boxes, four rows of sixteen columns each.
    localparam logic [3:0] SBOX_TAB [0:7][0:3][0:15] = '{
        '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,
            4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
          '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,
            4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
          '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,
            4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
          '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,
            4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
        '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,
            4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
          '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,
            4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
          '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,
            4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
          '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,
            4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
        '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,
            4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
          '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,
            4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
          '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,
            4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
          '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,
            4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
        '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,
            4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
          '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,
            4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
          '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,
            4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
          '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,
            4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
        '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,
            4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
          '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,
            4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
          '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,
            4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
          '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,
            4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
        '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,
            4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
          '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,
            4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
          '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,
            4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
          '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,
            4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
        '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,
            4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
          '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,
            4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
          '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,
            4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
          '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,
            4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
        '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,
            4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
          '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,
            4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
          '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,
            4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
          '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,
            4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
    };

    // Vector position of the right-half bit feeding expanded bit k (MSB first).
    function automatic logic [4:0] exp_pos(input int unsigned k);
        return 5'(HALF_W - int'(EXP_SRC[k]));
    endfunction

    // Vector position of the S-box word bit feeding P output bit k (MSB first).
    function automatic logic [4:0] perm_pos(input int unsigned k);
        return 5'(HALF_W - int'(PERM_SRC[k]));
    endfunction

    // Outer bits choose the row, inner four bits the column.
    function automatic logic [3:0] sbox_lookup(input logic [2:0] box,
                                               input logic [5:0] grp);
        logic [1:0] row;
        logic [3:0] col;
        row = {grp[5], grp[0]};
        col = grp[4:1];
        return SBOX_TAB[box][row][col];
    endfunction

endpackage

// ----- design/desrf_if.sv -----
// ----------------------------------------------------------------------------
// desrf_in_if / desrf_out_if
// Valid/ready channels carrying the round function's input and result beats.
// ----------------------------------------------------------------------------
interface desrf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] right_half;
    logic [47:0] round_key;

    modport source (output valid, output right_half, output round_key, input ready);
    modport sink   (input valid, input right_half, input round_key, output ready);
endinterface

interface desrf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] f_result;

    modport source (output valid, output f_result, input ready);
    modport sink   (input valid, input f_result, output ready);
endinterface

// ----- design/des_round_function_top.sv -----
// ----------------------------------------------------------------------------
// des_round_function_top
// DES round (Feistel) function with registered input and result stages.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  i_in    | in        | right_half[31:0], round_key[47:0]
//  o_out   | out       | f_result[31:0]
//
//  One beat is accepted every cycle while the result side is not stalled; its
//  result passes from the input register into the result register and out.
//  Throughput is one beat per cycle without stalls. The single path between
//  registers, through E, the key XOR, the S-boxes and P, sets the clock rate.
//  Reset is synchronous, active low, and empties both stages.
//  A stalled result holds the result register; an empty input stage takes one
//  further beat, then i_in.ready stays low until the result beat leaves.
// ----------------------------------------------------------------------------
module des_round_function_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    desrf_in_if.sink    i_in,
    desrf_out_if.source o_out
);
    import desrf_pkg::*;

    t_stage            stage;
    logic              take;
    logic [HALF_W-1:0] f_value;

    // Input register stage.
    desrf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_stage (stage)
    );

    // Round function logic between the two registers.
    desrf_f_logic u_f_logic (
        .i_right_half (stage.right_half),
        .i_round_key  (stage.round_key),
        .o_f_result   (f_value)
    );

    // Result register stage.
    desrf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage.valid),
        .i_result (f_value),
        .o_take   (take),
        .o_out    (o_out)
    );
endmodule

// ----- design/desrf_in_reg.sv -----
// ----------------------------------------------------------------------------
// desrf_in_reg
// Input register stage: captures one beat and holds it until the result
// register can take the computed value.
// ----------------------------------------------------------------------------
module desrf_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    desrf_in_if.sink         i_in,
    input  logic             i_take,
    output desrf_pkg::t_stage o_stage
);
    import desrf_pkg::*;

    logic              r_valid;
    logic [HALF_W-1:0] r_half;
    logic [KEY_W-1:0]  r_key;
    logic              n_valid;
    logic              accept;

    // The stage is free when empty or when its content moves on this cycle.
    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_half <= i_in.right_half;
            r_key  <= i_in.round_key;
        end
    end

    assign o_stage.valid      = r_valid;
    assign o_stage.right_half = r_half;
    assign o_stage.round_key  = r_key;
endmodule

// ----- design/desrf_f_logic.sv -----
// ----------------------------------------------------------------------------
// desrf_f_logic
// Combinational DES f function: expansion E, key mix, S-boxes and P.
// ----------------------------------------------------------------------------
module desrf_f_logic (
    input  logic [31:0] i_right_half,
    input  logic [47:0] i_round_key,
    output logic [31:0] o_f_result
);
    import desrf_pkg::*;

    logic [KEY_W-1:0]  expanded;
    logic [KEY_W-1:0]  mixed;
    logic [HALF_W-1:0] sbox_word;

    // Expansion E, with bit 1 as the most significant bit.
    always_comb begin
        for (int unsigned k = 0; k < KEY_W; k++) begin
            expanded[KEY_W-1-k] = i_right_half[exp_pos(k)];
        end
    end

    assign mixed = expanded ^ i_round_key;

    // Eight parallel S-box lookups, S1 in the top nibble.
    always_comb begin
        for (int unsigned g = 0; g < N_BOX; g++) begin
            sbox_word[HALF_W-1-NIB_W*g -: NIB_W] =
                sbox_lookup(3'(g), mixed[KEY_W-1-GRP_W*g -: GRP_W]);
        end
    end

    // Permutation P.
    always_comb begin
        for (int unsigned k = 0; k < HALF_W; k++) begin
            o_f_result[HALF_W-1-k] = sbox_word[perm_pos(k)];
        end
    end
endmodule

// ----- design/desrf_out_reg.sv -----
// ----------------------------------------------------------------------------
// desrf_out_reg
// Result register: presents one result beat and holds it while stalled.
// ----------------------------------------------------------------------------
module desrf_out_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_result,
    output logic        o_take,
    desrf_out_if.source o_out
);
    import desrf_pkg::*;

    logic              r_valid;
    logic [HALF_W-1:0] r_result;

    // A new value may be loaded when empty or when the current beat leaves.
    assign o_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.f_result = r_result;
endmodule

// ----- design/desrf_checker.sv -----
// ----------------------------------------------------------------------------
// desrf_checker
// Port-level assertions for the DES round function, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module desrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_result
);
    logic in_beat;

    assign in_beat = i_in_valid && i_in_ready;

    // Reset empties the result stage.
    `DESRF_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

    // A stalled result beat stays offered and unchanged.
    `DESRF_ASSERT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `DESRF_ASSERT(a_hold_data, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_result))

    // With nothing waiting at the output the block must take a beat.
    `DESRF_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)

    // An accepted beat moves into the result register at the next edge when
    // the result side is not stalled there, and is then offered at the output.
    `DESRF_ASSERT(a_latency, i_clk, i_rst_n, in_beat ##1 i_out_ready |=> i_out_valid)
endmodule

bind des_round_function_top desrf_checker u_desrf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.f_result)
);
